// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the level meter RTL.
// No dependencies; the macros compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ARPM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ARPM_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ARPM_ASSERT(label, clk, rst, prop, msg)
`define ARPM_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== hw/rtl/arpm_pkg.sv =====
// Shared constants and types for the RMS / peak level meter.
// No dependencies; used by arpm_ctrl, arpm_datapath and the top level.
package arpm_pkg;

   // sample format
   localparam int SAMPLE_BITS = 10;
   localparam int MID_SCALE   = 1 << (SAMPLE_BITS - 1);
   localparam int OUT_W       = 10;

   // window accumulation
   localparam int MAX_WINDOW  = 1024;
   localparam int COUNT_W     = 11;
   localparam int SUM_W       = 29;
   localparam int SQ_W        = 2 * SAMPLE_BITS;

   // peak hold, Q.8
   localparam int FRAC_BITS   = 8;
   localparam int HOLD_W      = 18;
   localparam int DECAY_W     = 9;
   localparam int DECAY_ONE   = 256;
   localparam int PROD_W      = HOLD_W + DECAY_W;

   // configuration port
   localparam int CSR_DATA_W       = 11;
   localparam int WINDOW_LEN_RESET = 192;
   localparam int PEAK_DECAY_RESET = 230;

   // serial divider and square root
   localparam int DIV_STEPS   = SUM_W;
   localparam int RAD_W       = 2 * ((SUM_W + 1) / 2);
   localparam int SQRT_STEPS  = RAD_W / 2;
   localparam int ROOT_W      = SQRT_STEPS;
   localparam int SREM_W      = ROOT_W + 2;
   localparam int STEP_W      = $clog2(DIV_STEPS);

   typedef enum logic {
      CSR_WINDOW_LEN = 1'b0,
      CSR_PEAK_DECAY = 1'b1
   } csr_index_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic accumulate;
      logic div_step;
      logic div_last;
      logic sqrt_step;
      logic publish;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic window_done;
   } dp_status_type;

endpackage

// ===== hw/rtl/audio_rms_peak_meter_unit.sv =====
// Windowed RMS and peak-hold level meter. A sample that does not close a window
// is accepted, then accumulated; a new sample is taken only once the last is accumulated.
// A window's last sample goes through accept, accumulate, serial divide (one
// quotient bit a cycle), serial square root and result load.
// The result waits in an output register; a new result load waits while it is stalled.
// Synchronous reset clears accumulators and hold; window_len 192, peak_decay 230.
module audio_rms_peak_meter_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  arpm_pkg::csr_index_type             csr_index,
   input  logic [arpm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [arpm_pkg::SAMPLE_BITS-1:0]    req_raw_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [arpm_pkg::OUT_W-1:0]          rsp_rms_level,
   output logic [arpm_pkg::OUT_W-1:0]          rsp_peak_instant,
   output logic [arpm_pkg::OUT_W-1:0]          rsp_peak_hold
);
   import arpm_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencing
   arpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // arithmetic and storage
   arpm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_raw_sample   (req_raw_sample),
      .rsp_rms_level    (rsp_rms_level),
      .rsp_peak_instant (rsp_peak_instant),
      .rsp_peak_hold    (rsp_peak_hold)
   );

endmodule

// ===== hw/rtl/arpm_datapath.sv =====
// Datapath of the level meter: config registers, window accumulators,
// serial divider, serial square root, peak hold and result register.
// Depends on arpm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module arpm_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  arpm_pkg::dp_cmd_type                cmd,
   output arpm_pkg::dp_status_type             status,
   input  logic                                csr_wr_en,
   input  arpm_pkg::csr_index_type             csr_index,
   input  logic [arpm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [arpm_pkg::SAMPLE_BITS-1:0]    req_raw_sample,
   output logic [arpm_pkg::OUT_W-1:0]          rsp_rms_level,
   output logic [arpm_pkg::OUT_W-1:0]          rsp_peak_instant,
   output logic [arpm_pkg::OUT_W-1:0]          rsp_peak_hold
);
   import arpm_pkg::*;

   // configuration
   logic [COUNT_W-1:0]     window_len_ff;
   logic [DECAY_W-1:0]     peak_decay_ff;
   logic [COUNT_W-1:0]     len_eff;
   logic [DECAY_W-1:0]     decay_eff;

   // window state
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0] peak_ff, peak_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [HOLD_W-1:0]      hold_ff, hold_in;
   logic [SAMPLE_BITS-1:0] mag;
   logic [SQ_W-1:0]        sq;

   // divider
   logic [COUNT_W-1:0]     rem_ff, rem_in;
   logic [SUM_W-1:0]       quo_ff, quo_in;
   logic [COUNT_W:0]       div_trial, div_diff;
   logic                   div_ge;

   // square root
   logic [RAD_W-1:0]       rad_ff;
   logic [SREM_W-1:0]      srem_ff, srem_in, srem_shift, sqrt_trial;
   logic [ROOT_W-1:0]      root_ff, root_in;
   logic                   sqrt_ge;

   // peak decay
   logic [PROD_W-1:0]      decay_prod;
   logic [HOLD_W-1:0]      decayed_ff;
   logic [HOLD_W-1:0]      peak_q;

   // results
   logic [OUT_W-1:0]       rms_ff, pk_ff, ph_ff, rms_clamped;

   // effective window length and decay
   always_comb begin
      if (window_len_ff == '0) begin
         len_eff = COUNT_W'(1);
      end else if (window_len_ff > COUNT_W'(MAX_WINDOW)) begin
         len_eff = COUNT_W'(MAX_WINDOW);
      end else begin
         len_eff = window_len_ff;
      end
      if (peak_decay_ff > DECAY_W'(DECAY_ONE)) begin
         decay_eff = DECAY_W'(DECAY_ONE);
      end else begin
         decay_eff = peak_decay_ff;
      end
   end

   // centered magnitude and accumulation
   assign mag      = (sample_ff >= SAMPLE_BITS'(MID_SCALE)) ?
                     sample_ff - SAMPLE_BITS'(MID_SCALE) :
                     SAMPLE_BITS'(MID_SCALE) - sample_ff;
   assign sq       = mag * mag;
   assign sum_in   = sum_ff + SUM_W'(sq);
   assign peak_in  = (mag > peak_ff) ? mag : peak_ff;
   assign count_in = count_ff + COUNT_W'(1);

   assign status.window_done = (count_in >= len_eff);

   // restoring divider, one quotient bit per step
   assign div_trial = {rem_ff, quo_ff[SUM_W-1]};
   assign div_ge    = (div_trial >= {1'b0, count_ff});
   assign div_diff  = div_trial - {1'b0, count_ff};
   assign rem_in    = div_ge ? div_diff[COUNT_W-1:0] : div_trial[COUNT_W-1:0];
   assign quo_in    = {quo_ff[SUM_W-2:0], div_ge};

   // digit-by-digit square root, one root bit per step
   assign srem_shift = {srem_ff[SREM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign sqrt_trial = {root_ff, 2'b01};
   assign sqrt_ge    = (srem_shift >= sqrt_trial);
   assign srem_in    = sqrt_ge ? srem_shift - sqrt_trial : srem_shift;
   assign root_in    = {root_ff[ROOT_W-2:0], sqrt_ge};

   assign rms_clamped = (root_ff > ROOT_W'(MID_SCALE)) ? OUT_W'(MID_SCALE) :
                        root_ff[OUT_W-1:0];

   // hold decay and new peak
   assign decay_prod = hold_ff * decay_eff;
   assign peak_q     = {peak_ff, {FRAC_BITS{1'b0}}};
   assign hold_in    = (peak_q > decayed_ff) ? peak_q : decayed_ff;

   // control-visible state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= COUNT_W'(WINDOW_LEN_RESET);
         peak_decay_ff <= DECAY_W'(PEAK_DECAY_RESET);
         sum_ff        <= '0;
         peak_ff       <= '0;
         count_ff      <= '0;
         hold_ff       <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_WINDOW_LEN: window_len_ff <= csr_wdata;
               CSR_PEAK_DECAY: peak_decay_ff <= csr_wdata[DECAY_W-1:0];
               default: ;
            endcase
         end
         if (cmd.accumulate) begin
            sum_ff   <= sum_in;
            peak_ff  <= peak_in;
            count_ff <= count_in;
         end
         if (cmd.publish) begin
            hold_ff  <= hold_in;
            sum_ff   <= '0;
            peak_ff  <= '0;
            count_ff <= '0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= req_raw_sample;
      end
      if (cmd.accumulate && status.window_done) begin
         quo_ff <= sum_in;
         rem_ff <= '0;
      end
      if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
      if (cmd.div_last) begin
         rad_ff  <= RAD_W'(quo_in);
         srem_ff <= '0;
         root_ff <= '0;
      end
      if (cmd.sqrt_step) begin
         rad_ff  <= rad_ff << 2;
         srem_ff <= srem_in;
         root_ff <= root_in;
      end
      decayed_ff <= decay_prod[FRAC_BITS +: HOLD_W];
      if (cmd.publish) begin
         rms_ff <= rms_clamped;
         pk_ff  <= peak_ff;
         ph_ff  <= hold_in[FRAC_BITS +: OUT_W];
      end
   end

   assign rsp_rms_level    = rms_ff;
   assign rsp_peak_instant = pk_ff;
   assign rsp_peak_hold    = ph_ff;

   `ARPM_ASSERT(a_count_bound, clock, reset, count_ff <= COUNT_W'(MAX_WINDOW), "count past max window")
   `ARPM_ASSERT(a_peak_bound, clock, reset, peak_ff <= SAMPLE_BITS'(MID_SCALE), "peak above mid-scale")
   `ARPM_ASSERT(a_hold_ge_peak, clock, reset, cmd.publish |=> (hold_ff[FRAC_BITS +: OUT_W] >= $past(peak_ff)), "hold below window peak")

endmodule

// ===== hw/rtl/arpm_ctrl.sv =====
// Sequencing controller of the level meter: sample handshake, divide and
// square root step counts, result handshake. Depends on arpm_pkg, assert_macros.svh.
`include "assert_macros.svh"

module arpm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output arpm_pkg::dp_cmd_type    cmd,
   input  arpm_pkg::dp_status_type status
);
   import arpm_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ACC,
      S_DIV,
      S_SQRT,
      S_PUB
   } state_type;

   state_type          state_ff;
   logic [STEP_W-1:0]  step_ff;
   logic               rsp_valid_ff;

   // commands to the datapath
   always_comb begin
      cmd            = '0;
      cmd.capture    = (state_ff == S_IDLE) && req_valid;
      cmd.accumulate = (state_ff == S_ACC);
      cmd.div_step   = (state_ff == S_DIV);
      cmd.div_last   = (state_ff == S_DIV) && (step_ff == STEP_W'(DIV_STEPS - 1));
      cmd.sqrt_step  = (state_ff == S_SQRT);
      cmd.publish    = (state_ff == S_PUB) && (!rsp_valid_ff || !rsp_stall);
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // state, step counter and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new result replaces one taken in the same cycle
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_ACC;
               end
            end
            S_ACC: begin
               step_ff  <= '0;
               state_ff <= status.window_done ? S_DIV : S_IDLE;
            end
            S_DIV: begin
               if (cmd.div_last) begin
                  step_ff  <= '0;
                  state_ff <= S_SQRT;
               end else begin
                  step_ff <= step_ff + STEP_W'(1);
               end
            end
            S_SQRT: begin
               if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
                  step_ff  <= '0;
                  state_ff <= S_PUB;
               end else begin
                  step_ff <= step_ff + STEP_W'(1);
               end
            end
            S_PUB: begin
               if (cmd.publish) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `ARPM_ASSERT(a_acc_after_accept, clock, reset,
      (req_valid && !req_stall) |=> (state_ff == S_ACC), "accepted sample not accumulated")
   `ARPM_NEVER(a_no_overwrite, clock, reset,
      cmd.publish && rsp_valid_ff && rsp_stall, "result overwritten while stalled")
   `ARPM_ASSERT(a_sqrt_steps, clock, reset,
      (state_ff == S_SQRT) |-> (step_ff < STEP_W'(SQRT_STEPS)), "square root step out of range")

endmodule

// ===== test/audio_rms_peak_meter_unit_test.sv =====
// Self-checking testbench for the windowed RMS / peak-hold level meter.
// Depends on arpm_pkg and audio_rms_peak_meter_unit; predicts every window result
// from its own model of the meter and checks each rsp transaction against it.
module audio_rms_peak_meter_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import arpm_pkg::*;

   localparam int SETTLE_CYCLES = 64;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_ITEMS  = 250;

   typedef enum int {
      FULL_RANGE,
      QUIET,
      FULL_SCALE,
      MIXED
   } signal_style_type;

   typedef struct packed {
      logic [OUT_W-1:0] rms_level;
      logic [OUT_W-1:0] peak_instant;
      logic [OUT_W-1:0] peak_hold;
   } level_reading_type;

   // block ports
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   csr_index_type          csr_index = CSR_WINDOW_LEN;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [SAMPLE_BITS-1:0] req_raw_sample = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [OUT_W-1:0]       rsp_rms_level;
   logic [OUT_W-1:0]       rsp_peak_instant;
   logic [OUT_W-1:0]       rsp_peak_hold;

   // meter model: configuration copy and window state
   logic [COUNT_W-1:0]     shadow_window_len = COUNT_W'(WINDOW_LEN_RESET);
   logic [DECAY_W-1:0]     shadow_peak_decay = DECAY_W'(PEAK_DECAY_RESET);
   logic [SUM_W-1:0]       model_sum_sq = '0;
   logic [OUT_W-1:0]       model_win_peak = '0;
   logic [COUNT_W-1:0]     model_win_count = '0;
   logic [HOLD_W-1:0]      model_hold_q8 = '0;

   logic [SAMPLE_BITS-1:0] sample_queue[$];
   level_reading_type      pending_readings[$];

   int                     error_count = 0;
   int                     reading_count = 0;
   int                     cycle_count = 0;
   int                     gap_left, burst_left, stall_run;
   bit                     await_drain, stall_now;

   always #5 clock = ~clock;

   audio_rms_peak_meter_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_raw_sample   (req_raw_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_rms_level    (rsp_rms_level),
      .rsp_peak_instant (rsp_peak_instant),
      .rsp_peak_hold    (rsp_peak_hold)
   );

   task automatic report_mismatch(input string detail);
      $display("mismatch at %0t ns: %s", $realtime, detail);
      error_count++;
   endtask

   // Advance the meter model by one sample; queue a reading when the window closes.
   function automatic void predict_sample(input logic [SAMPLE_BITS-1:0] raw);
      logic [OUT_W-1:0]   mag;
      logic [COUNT_W-1:0] eff_len;
      logic [DECAY_W-1:0] eff_decay;
      logic [SUM_W-1:0]   mean_sq;
      logic [ROOT_W-1:0]  root, trial;
      logic [63:0]        trial_sq;
      logic [PROD_W-1:0]  decayed;
      logic [HOLD_W-1:0]  peak_q8;
      level_reading_type  reading;

      mag = (raw >= MID_SCALE) ? OUT_W'(raw - MID_SCALE) : OUT_W'(MID_SCALE - raw);
      eff_len = shadow_window_len;
      if (eff_len == 0) eff_len = COUNT_W'(1);
      if (eff_len > MAX_WINDOW) eff_len = COUNT_W'(MAX_WINDOW);
      eff_decay = (shadow_peak_decay > DECAY_ONE) ? DECAY_W'(DECAY_ONE) : shadow_peak_decay;

      if (mag > model_win_peak) model_win_peak = mag;
      model_sum_sq = model_sum_sq + SUM_W'(mag) * SUM_W'(mag);
      model_win_count = model_win_count + 1'b1;
      if (model_win_count < eff_len) return;

      // mean and truncated square root, bit by bit from the top
      mean_sq = model_sum_sq / SUM_W'(model_win_count);
      root = '0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
         trial = root | (ROOT_W'(1) << b);
         trial_sq = 64'(trial) * 64'(trial);
         if (trial_sq <= 64'(mean_sq)) root = trial;
      end
      if (root > MID_SCALE) root = ROOT_W'(MID_SCALE);

      // hold decays first, then is raised to the new window peak
      decayed = (PROD_W'(model_hold_q8) * PROD_W'(eff_decay)) >> FRAC_BITS;
      peak_q8 = HOLD_W'(model_win_peak) << FRAC_BITS;
      model_hold_q8 = (peak_q8 > decayed) ? peak_q8 : decayed[HOLD_W-1:0];

      reading.rms_level    = root[OUT_W-1:0];
      reading.peak_instant = model_win_peak;
      reading.peak_hold    = OUT_W'(model_hold_q8 >> FRAC_BITS);
      pending_readings.push_back(reading);

      model_sum_sq = '0;
      model_win_peak = '0;
      model_win_count = '0;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] next_sample(input signal_style_type style);
      signal_style_type pick;
      pick = style;
      if (pick == MIXED) pick = signal_style_type'($urandom_range(0, 2));
      case (pick)
         QUIET:      return SAMPLE_BITS'(MID_SCALE - 8 + $urandom_range(0, 16));
         FULL_SCALE: begin
            case ($urandom_range(0, 3))
               0: return '0;
               1: return '1;
               2: return SAMPLE_BITS'(1);
               default: return SAMPLE_BITS'((1 << SAMPLE_BITS) - 2);
            endcase
         end
         default:    return SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
      endcase
   endfunction

   // Register write; only called while the meter is idle.
   task automatic write_register(input csr_index_type index, input int value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= CSR_DATA_W'(value);
      if (index == CSR_WINDOW_LEN) shadow_window_len = value[COUNT_W-1:0];
      else shadow_peak_decay = value[DECAY_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Wait until every queued sample is taken and every reading has come back, then settle.
   task automatic drain_and_settle();
      while (sample_queue.size() != 0 || req_valid || pending_readings.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_samples(input int count, input signal_style_type style);
      @(negedge clock);
      repeat (count) sample_queue.push_back(next_sample(style));
      drain_and_settle();
   endtask

   task automatic run_directed(input logic [SAMPLE_BITS-1:0] values[$]);
      @(negedge clock);
      foreach (values[i]) sample_queue.push_back(values[i]);
      drain_and_settle();
   endtask

   // Stimulus sequence
   initial begin
      int random_items;
      int window, decay, count;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: two samples leave a partial window, then shorten it
      run_directed('{10'd0, 10'd1023});
      write_register(CSR_WINDOW_LEN, 2);
      run_directed('{10'd512});

      // one-sample windows, no decay: magnitude extremes and bit patterns
      write_register(CSR_WINDOW_LEN, 1);
      write_register(CSR_PEAK_DECAY, DECAY_ONE);
      run_directed('{10'd1023, 10'd512, 10'd511, 10'd513, 10'd1, 10'd1022,
                     10'h2AA, 10'h155});

      // full decay drops the hold to the new peak
      write_register(CSR_PEAK_DECAY, 0);
      run_directed('{10'd512, 10'd700});

      // decay above one saturates
      write_register(CSR_PEAK_DECAY, 511);
      run_directed('{10'd0, 10'd600});

      // zero window length acts as one sample
      write_register(CSR_WINDOW_LEN, 0);
      run_directed('{10'd300, 10'd800});

      write_register(CSR_WINDOW_LEN, 4);
      write_register(CSR_PEAK_DECAY, 128);
      run_directed('{10'd0, 10'd1023, 10'd0, 10'd1023});

      // long window at full scale; an oversized length saturates and keeps it
      // open, then a length below the count closes it on the next sample
      write_register(CSR_WINDOW_LEN, MAX_WINDOW);
      write_register(CSR_PEAK_DECAY, DECAY_ONE);
      run_samples(200, FULL_SCALE);
      write_register(CSR_WINDOW_LEN, (1 << COUNT_W) - 1);
      run_samples(40, MIXED);
      write_register(CSR_WINDOW_LEN, 100);
      run_samples(4, MIXED);

      // random phases, mostly short windows
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       window = 0;
            7, 8:    window = $urandom_range(9, 40);
            9:       window = $urandom_range(41, 200);
            default: window = $urandom_range(1, 8);
         endcase
         case ($urandom_range(0, 5))
            0:       decay = 0;
            1:       decay = DECAY_ONE;
            2:       decay = $urandom_range(DECAY_ONE + 1, (1 << DECAY_W) - 1);
            default: decay = $urandom_range(1, DECAY_ONE - 1);
         endcase
         if ($urandom_range(0, 3) != 0) write_register(CSR_WINDOW_LEN, window);
         if ($urandom_range(0, 3) != 0) write_register(CSR_PEAK_DECAY, decay);
         count = $urandom_range(10, 60);
         run_samples(count, signal_style_type'($urandom_range(0, 3)));
         random_items += count;
      end

      drain_and_settle();
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Sample driver: bursts of transactions with random gaps and occasional drains
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
         burst_left = 0;
         await_drain = 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (await_drain && !req_valid && pending_readings.size() == 0) await_drain = 1'b0;
         if (gap_left != 0 || await_drain || sample_queue.size() == 0) begin
            req_valid <= 1'b0;
            if (gap_left != 0) gap_left--;
         end else begin
            req_valid <= 1'b1;
            req_raw_sample <= sample_queue.pop_front();
            if (burst_left == 0) burst_left = $urandom_range(1, 24);
            burst_left--;
            if (burst_left == 0) begin
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               await_drain = ($urandom_range(0, 15) == 0);
            end
         end
      end
   end

   // Result stall pattern: runs of stalling and free-flowing cycles
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_run = 0;
      end else begin
         if (stall_run == 0) begin
            stall_now = ($urandom_range(0, 3) == 0);
            stall_run = stall_now ? $urandom_range(1, 30) : $urandom_range(1, 60);
            rsp_stall <= stall_now;
         end
         stall_run--;
      end
   end

   // Accepted sample transactions feed the model
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) predict_sample(req_raw_sample);
   end

   // Accepted result transactions are checked against the oldest prediction
   always @(posedge clock) begin
      level_reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            report_mismatch($sformatf("reading %0d arrived with none expected",
                                      reading_count));
         end else begin
            want = pending_readings.pop_front();
            if (rsp_rms_level !== want.rms_level)
               report_mismatch($sformatf("reading %0d rms_level got %0d want %0d",
                                         reading_count, rsp_rms_level, want.rms_level));
            if (rsp_peak_instant !== want.peak_instant)
               report_mismatch($sformatf("reading %0d peak_instant got %0d want %0d",
                                         reading_count, rsp_peak_instant,
                                         want.peak_instant));
            if (rsp_peak_hold !== want.peak_hold)
               report_mismatch($sformatf("reading %0d peak_hold got %0d want %0d",
                                         reading_count, rsp_peak_hold, want.peak_hold));
         end
         reading_count++;
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d readings outstanding", cycle_count,
                  pending_readings.size());
         $display("FAILURE");
         $finish;
      end
   end

endmodule
